### src/rfcs_pkg.sv
// shared types, codes and widths for the reference frame context selector
package rfcs_pkg;

    localparam int CMD_W = 3;
    localparam int CTX_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CMD_W-1:0] CMD_INTERP = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INTRA_INTER = 3'd1;
    localparam logic [CMD_W-1:0] CMD_COMP_INTER = 3'd2;
    localparam logic [CMD_W-1:0] CMD_COMP_REF = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SINGLE_P1 = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SINGLE_P2 = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_FIXED_REF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMP_VAR_REF_FIRST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COMP_VAR_REF_SECOND = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REF_SIGN_BIAS = 2'd3;

    localparam logic [1:0] NO_FILTER = 2'd3;
    localparam logic [1:0] REF_INTRA = 2'd0;
    localparam logic [1:0] REF_LAST = 2'd1;
    localparam logic [1:0] REF_GOLDEN = 2'd2;
    localparam logic [1:0] REF_ALT = 2'd3;

    typedef struct packed {
        logic              valid;
        logic              inter_mode;
        logic [1:0]        filter;
        logic [1:0]        ref0;
        logic signed [2:0] ref1;
    } nbr_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        nbr_t             left;
        nbr_t             above;
    } req_t;

    typedef struct packed {
        logic [1:0] fixed_ref;
        logic [1:0] comp_var_ref_first;
        logic [1:0] comp_var_ref_second;
        logic [3:0] ref_sign_bias;
    } cfg_t;

endpackage

### src/rfcs_if.sv
// request and result channel interfaces
interface rfcs_req_if;
    logic                          valid;
    logic                          ready;
    logic [rfcs_pkg::CMD_W-1:0]    command;
    logic                          left_valid;
    logic                          left_inter_mode;
    logic [1:0]                    left_filter;
    logic [1:0]                    left_ref0;
    logic signed [2:0]             left_ref1;
    logic                          above_valid;
    logic                          above_inter_mode;
    logic [1:0]                    above_filter;
    logic [1:0]                    above_ref0;
    logic signed [2:0]             above_ref1;

    modport source (
        output valid, command, left_valid, left_inter_mode, left_filter, left_ref0,
               left_ref1, above_valid, above_inter_mode, above_filter, above_ref0,
               above_ref1,
        input  ready
    );
    modport sink (
        input  valid, command, left_valid, left_inter_mode, left_filter, left_ref0,
               left_ref1, above_valid, above_inter_mode, above_filter, above_ref0,
               above_ref1,
        output ready
    );
endinterface

interface rfcs_res_if;
    logic                       valid;
    logic                       ready;
    logic [rfcs_pkg::CTX_W-1:0] context_res;

    modport source (output valid, context_res, input ready);
    modport sink (input valid, context_res, output ready);
endinterface

### src/rfcs_cfg.sv
// frame-level compound reference configuration registers
module rfcs_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rfcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rfcs_pkg::CFG_DATA_W-1:0] cfg_data,
    output rfcs_pkg::cfg_t                  cfg
);

    rfcs_pkg::cfg_t cfg_reg;
    rfcs_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                rfcs_pkg::REG_FIXED_REF:           cfg_next.fixed_ref = cfg_data[1:0];
                rfcs_pkg::REG_COMP_VAR_REF_FIRST:  cfg_next.comp_var_ref_first = cfg_data[1:0];
                rfcs_pkg::REG_COMP_VAR_REF_SECOND: cfg_next.comp_var_ref_second = cfg_data[1:0];
                rfcs_pkg::REG_REF_SIGN_BIAS:       cfg_next.ref_sign_bias = cfg_data;
                default:                           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fixed_ref           <= 2'd3;
            cfg_reg.comp_var_ref_first  <= 2'd1;
            cfg_reg.comp_var_ref_second <= 2'd2;
            cfg_reg.ref_sign_bias       <= 4'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/rfcs_ctx.sv
// context decision trees for one registered request
module rfcs_ctx (
    input  rfcs_pkg::req_t              req,
    input  rfcs_pkg::cfg_t              cfg,
    output logic [rfcs_pkg::CTX_W-1:0]  context_res
);

    function automatic logic signed [2:0] sx(input logic [1:0] v);
        return $signed({1'b0, v});
    endfunction

    function automatic logic is_intra(input rfcs_pkg::nbr_t n);
        return n.ref0 == rfcs_pkg::REF_INTRA;
    endfunction

    function automatic logic is_comp(input rfcs_pkg::nbr_t n);
        return n.ref1 > 3'sd0;
    endfunction

    function automatic logic signed [2:0] ref_at(input rfcs_pkg::nbr_t n, input logic idx);
        return idx ? n.ref1 : sx(n.ref0);
    endfunction

    function automatic logic has_ref(input rfcs_pkg::nbr_t n, input logic [1:0] f);
        return (n.ref0 == f) || (n.ref1 == sx(f));
    endfunction

    function automatic logic [2:0] ctx_interp(input rfcs_pkg::nbr_t l, input rfcs_pkg::nbr_t a);
        logic [1:0] li;
        logic [1:0] ai;
        logic [1:0] r;
        li = (l.valid && l.inter_mode) ? l.filter : rfcs_pkg::NO_FILTER;
        ai = (a.valid && a.inter_mode) ? a.filter : rfcs_pkg::NO_FILTER;
        if (li == ai)
            r = li;
        else if (li == rfcs_pkg::NO_FILTER)
            r = ai;
        else if (ai == rfcs_pkg::NO_FILTER)
            r = li;
        else
            r = rfcs_pkg::NO_FILTER;
        return {1'b0, r};
    endfunction

    function automatic logic [2:0] ctx_intra_inter(input rfcs_pkg::nbr_t l,
                                                   input rfcs_pkg::nbr_t a);
        logic li;
        logic ai;
        logic [2:0] r;
        li = is_intra(l);
        ai = is_intra(a);
        if (a.valid && l.valid)
            r = (li && ai) ? 3'd3 : {2'b00, li || ai};
        else if (a.valid)
            r = ai ? 3'd2 : 3'd0;
        else if (l.valid)
            r = li ? 3'd2 : 3'd0;
        else
            r = 3'd0;
        return r;
    endfunction

    function automatic logic [2:0] ctx_comp_inter(input rfcs_pkg::nbr_t l,
                                                  input rfcs_pkg::nbr_t a,
                                                  input logic [1:0] fx);
        rfcs_pkg::nbr_t e;
        logic [2:0] r;
        e = a.valid ? a : l;
        if (a.valid && l.valid)
        begin
            if (!is_comp(a) && !is_comp(l))
                r = {2'b00, (a.ref0 == fx) ^ (l.ref0 == fx)};
            else if (!is_comp(a))
                r = 3'd2 + {2'b00, (a.ref0 == fx) || (a.ref0 == rfcs_pkg::REF_INTRA)};
            else if (!is_comp(l))
                r = 3'd2 + {2'b00, (l.ref0 == fx) || (l.ref0 == rfcs_pkg::REF_INTRA)};
            else
                r = 3'd4;
        end
        else if (a.valid || l.valid)
            r = is_comp(e) ? 3'd3 : {2'b00, e.ref0 == fx};
        else
            r = 3'd1;
        return r;
    endfunction

    function automatic logic [2:0] ctx_comp_ref(input rfcs_pkg::nbr_t l,
                                                input rfcs_pkg::nbr_t a,
                                                input rfcs_pkg::cfg_t c);
        logic signed [2:0] fx;
        logic signed [2:0] v0;
        logic signed [2:0] v1;
        logic var_idx;
        logic ai;
        logic li;
        logic lsg;
        logic asg;
        rfcs_pkg::nbr_t e;
        logic signed [2:0] rr;
        logic signed [2:0] vra;
        logic signed [2:0] vrl;
        logic signed [2:0] vrc;
        logic signed [2:0] rfs;
        logic [2:0] r;
        fx = sx(c.fixed_ref);
        v0 = sx(c.comp_var_ref_first);
        v1 = sx(c.comp_var_ref_second);
        var_idx = !c.ref_sign_bias[c.fixed_ref];
        ai = is_intra(a);
        li = is_intra(l);
        lsg = !is_comp(l);
        asg = !is_comp(a);
        vra = asg ? sx(a.ref0) : ref_at(a, var_idx);
        vrl = lsg ? sx(l.ref0) : ref_at(l, var_idx);
        vrc = lsg ? vra : vrl;
        rfs = asg ? vra : vrl;
        if (a.valid && l.valid)
            e = ai ? l : a;
        else
            e = a.valid ? a : l;
        rr = is_comp(e) ? ref_at(e, var_idx) : sx(e.ref0);
        if (a.valid && l.valid)
        begin
            if (ai && li)
                r = 3'd2;
            else if (ai || li)
                r = (rr != v1) ? 3'd3 : 3'd1;
            else if ((vra == vrl) && (v1 == vra))
                r = 3'd0;
            else if (lsg && asg)
            begin
                if (((vra == fx) && (vrl == v0)) || ((vrl == fx) && (vra == v0)))
                    r = 3'd4;
                else if (vra == vrl)
                    r = 3'd3;
                else
                    r = 3'd1;
            end
            else if (lsg || asg)
            begin
                if ((vrc == v1) && (rfs != v1))
                    r = 3'd1;
                else if ((rfs == v1) && (vrc != v1))
                    r = 3'd2;
                else
                    r = 3'd4;
            end
            else
                r = (vra == vrl) ? 3'd4 : 3'd2;
        end
        else if (a.valid || l.valid)
        begin
            if (e.ref0 == rfcs_pkg::REF_INTRA)
                r = 3'd2;
            else if (is_comp(e))
                r = (rr != v1) ? 3'd4 : 3'd0;
            else
                r = (rr != v1) ? 3'd3 : 3'd0;
        end
        else
            r = 3'd2;
        return r;
    endfunction

    function automatic logic [2:0] ctx_single_p1(input rfcs_pkg::nbr_t l,
                                                 input rfcs_pkg::nbr_t a);
        logic ai;
        logic li;
        rfcs_pkg::nbr_t e;
        rfcs_pkg::nbr_t s;
        rfcs_pkg::nbr_t cn;
        logic [2:0] r;
        ai = is_intra(a);
        li = is_intra(l);
        if (a.valid && l.valid)
            e = ai ? l : a;
        else
            e = a.valid ? a : l;
        s = is_comp(a) ? l : a;
        cn = is_comp(a) ? a : l;
        if (a.valid && l.valid)
        begin
            if (ai && li)
                r = 3'd2;
            else if (ai || li)
            begin
                if (!is_comp(e))
                    r = (e.ref0 == rfcs_pkg::REF_LAST) ? 3'd4 : 3'd0;
                else
                    r = 3'd1 + {2'b00, has_ref(e, rfcs_pkg::REF_LAST)};
            end
            else if (!is_comp(a) && !is_comp(l))
                r = {1'b0, a.ref0 == rfcs_pkg::REF_LAST, 1'b0}
                  + {1'b0, l.ref0 == rfcs_pkg::REF_LAST, 1'b0};
            else if (is_comp(a) && is_comp(l))
                r = 3'd1 + {2'b00, has_ref(a, rfcs_pkg::REF_LAST)
                                   || has_ref(l, rfcs_pkg::REF_LAST)};
            else if (s.ref0 == rfcs_pkg::REF_LAST)
                r = 3'd3 + {2'b00, has_ref(cn, rfcs_pkg::REF_LAST)};
            else
                r = {2'b00, has_ref(cn, rfcs_pkg::REF_LAST)};
        end
        else if (a.valid || l.valid)
        begin
            if (is_intra(e))
                r = 3'd2;
            else if (!is_comp(e))
                r = (e.ref0 == rfcs_pkg::REF_LAST) ? 3'd4 : 3'd0;
            else
                r = 3'd1 + {2'b00, has_ref(e, rfcs_pkg::REF_LAST)};
        end
        else
            r = 3'd2;
        return r;
    endfunction

    function automatic logic [2:0] ctx_single_p2(input rfcs_pkg::nbr_t l,
                                                 input rfcs_pkg::nbr_t a);
        logic ai;
        logic li;
        logic cg;
        rfcs_pkg::nbr_t e;
        rfcs_pkg::nbr_t s;
        rfcs_pkg::nbr_t cn;
        rfcs_pkg::nbr_t o;
        logic [2:0] r;
        ai = is_intra(a);
        li = is_intra(l);
        if (a.valid && l.valid)
            e = ai ? l : a;
        else
            e = a.valid ? a : l;
        s = is_comp(a) ? l : a;
        cn = is_comp(a) ? a : l;
        o = (a.ref0 == rfcs_pkg::REF_LAST) ? l : a;
        cg = has_ref(cn, rfcs_pkg::REF_GOLDEN);
        if (a.valid && l.valid)
        begin
            if (ai && li)
                r = 3'd2;
            else if (ai || li)
            begin
                if (!is_comp(e))
                begin
                    if (e.ref0 == rfcs_pkg::REF_LAST)
                        r = 3'd3;
                    else
                        r = (e.ref0 == rfcs_pkg::REF_GOLDEN) ? 3'd4 : 3'd0;
                end
                else
                    r = has_ref(e, rfcs_pkg::REF_GOLDEN) ? 3'd3 : 3'd1;
            end
            else if (!is_comp(a) && !is_comp(l))
            begin
                if ((a.ref0 == rfcs_pkg::REF_LAST) && (l.ref0 == rfcs_pkg::REF_LAST))
                    r = 3'd3;
                else if ((a.ref0 == rfcs_pkg::REF_LAST) || (l.ref0 == rfcs_pkg::REF_LAST))
                    r = (o.ref0 == rfcs_pkg::REF_GOLDEN) ? 3'd4 : 3'd0;
                else
                    r = {1'b0, a.ref0 == rfcs_pkg::REF_GOLDEN, 1'b0}
                      + {1'b0, l.ref0 == rfcs_pkg::REF_GOLDEN, 1'b0};
            end
            else if (is_comp(a) && is_comp(l))
            begin
                if ((a.ref0 == l.ref0) && (a.ref1 == l.ref1))
                    r = (has_ref(a, rfcs_pkg::REF_GOLDEN)
                         || has_ref(l, rfcs_pkg::REF_GOLDEN)) ? 3'd3 : 3'd0;
                else
                    r = 3'd2;
            end
            else if (s.ref0 == rfcs_pkg::REF_GOLDEN)
                r = 3'd3 + {2'b00, cg};
            else if (s.ref0 == rfcs_pkg::REF_ALT)
                r = {2'b00, cg};
            else
                r = cg ? 3'd3 : 3'd1;
        end
        else if (a.valid || l.valid)
        begin
            if (is_intra(e) || ((e.ref0 == rfcs_pkg::REF_LAST) && !is_comp(e)))
                r = 3'd2;
            else if (!is_comp(e))
                r = (e.ref0 == rfcs_pkg::REF_GOLDEN) ? 3'd4 : 3'd0;
            else
                r = has_ref(e, rfcs_pkg::REF_GOLDEN) ? 3'd3 : 3'd0;
        end
        else
            r = 3'd2;
        return r;
    endfunction

    always_comb
    begin
        case (req.command)
            rfcs_pkg::CMD_INTERP:      context_res = ctx_interp(req.left, req.above);
            rfcs_pkg::CMD_INTRA_INTER: context_res = ctx_intra_inter(req.left, req.above);
            rfcs_pkg::CMD_COMP_INTER:
                context_res = ctx_comp_inter(req.left, req.above, cfg.fixed_ref);
            rfcs_pkg::CMD_COMP_REF:    context_res = ctx_comp_ref(req.left, req.above, cfg);
            rfcs_pkg::CMD_SINGLE_P1:   context_res = ctx_single_p1(req.left, req.above);
            rfcs_pkg::CMD_SINGLE_P2:   context_res = ctx_single_p2(req.left, req.above);
            default:                   context_res = '0;
        endcase
    end

endmodule

### src/ref_frame_context_select.sv
// top level of the reference frame context selector
//
// usage:
//   req carries one context request per item: a command that picks the
//   syntax element and the left and above neighbor info. res returns one
//   item per request with context_res, in request order.
//   cfg_we/cfg_index/cfg_data write the compound reference and sign bias
//   registers; write them only while no request is in flight.
// datapath: an accepted request is held in the input register req_reg; the
//   combinational context is then captured in res_data_reg, which drives res.
// throughput: one item per cycle while res.ready stays high, set by the input
//   register feeding the decision logic and the result register behind it.
// reset: both pipeline stages are emptied, req.ready comes up at once and
//   the registers return to fixed_ref 3, comp_var_ref_first 1,
//   comp_var_ref_second 2, ref_sign_bias 0.
// stall: while res.ready is low the result holds; the input register still
//   takes one more item, then req.ready drops until the result is taken.
module ref_frame_context_select (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rfcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rfcs_pkg::CFG_DATA_W-1:0] cfg_data,
    rfcs_req_if.sink                        req,
    rfcs_res_if.source                      res
);

    rfcs_pkg::cfg_t cfg;
    rfcs_pkg::req_t req_in;
    rfcs_pkg::req_t req_reg;
    logic           req_valid_reg;
    logic           req_valid_next;
    logic [rfcs_pkg::CTX_W-1:0] ctx;
    logic [rfcs_pkg::CTX_W-1:0] res_data_reg;
    logic           res_valid_reg;
    logic           res_valid_next;
    logic           res_free;
    logic           advance;
    logic           take_in;

    rfcs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    always_comb
    begin
        req_in.command          = req.command;
        req_in.left.valid       = req.left_valid;
        req_in.left.inter_mode  = req.left_inter_mode;
        req_in.left.filter      = req.left_filter;
        req_in.left.ref0        = req.left_ref0;
        req_in.left.ref1        = req.left_ref1;
        req_in.above.valid      = req.above_valid;
        req_in.above.inter_mode = req.above_inter_mode;
        req_in.above.filter     = req.above_filter;
        req_in.above.ref0       = req.above_ref0;
        req_in.above.ref1       = req.above_ref1;
    end

    rfcs_ctx u_ctx (
        .req         (req_reg),
        .cfg         (cfg),
        .context_res (ctx)
    );

    assign res_free  = !res_valid_reg || res.ready;
    assign advance   = req_valid_reg && res_free;
    assign req.ready = !req_valid_reg || res_free;
    assign take_in   = req.valid && req.ready;

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (take_in)
            req_valid_next = 1'b1;
        else if (advance)
            req_valid_next = 1'b0;
        res_valid_next = res_valid_reg;
        if (advance)
            res_valid_next = 1'b1;
        else if (res.ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
            req_reg <= req_in;
        if (advance)
            res_data_reg <= ctx;
    end

    assign res.valid       = res_valid_reg;
    assign res.context_res = res_data_reg;

endmodule

### src/rfcs_checker.sv
// port-level checks for the reference frame context selector
module rfcs_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_ready,
    input logic                       res_valid,
    input logic                       res_ready,
    input logic [rfcs_pkg::CTX_W-1:0] context_res
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(context_res))
        else $error("result changed while stalled");

    a_ctx_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> context_res <= 3'd4)
        else $error("context out of range");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> req_ready)
        else $error("request stalled with empty result stage");

endmodule

bind ref_frame_context_select rfcs_checker u_rfcs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_ready   (req.ready),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .context_res (res.context_res)
);

### verif/rfcs_checker.sv
// checker that predicts the context of each request and compares it with the result channel
module rfcs_context_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rfcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rfcs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            check_end,
    rfcs_req_if                             req,
    rfcs_res_if                             res,
    output int                              pending,
    output int                              fail_cnt
);

    typedef struct {
        rfcs_pkg::req_t             rq;
        logic [rfcs_pkg::CTX_W-1:0] ctx;
    } ctx_expect_t;

    ctx_expect_t    ctx_expect_q [$];
    rfcs_pkg::cfg_t frame_cfg = '{2'd3, 2'd1, 2'd2, 4'd0};

    initial
    begin
        fail_cnt = 0;
        pending  = 0;
    end

    task automatic report_mismatch(string msg);
        $display("%s", msg);
        fail_cnt++;
    endtask

    function automatic bit nb_intra(rfcs_pkg::nbr_t n);
        return n.ref0 == rfcs_pkg::REF_INTRA;
    endfunction

    function automatic bit nb_comp(rfcs_pkg::nbr_t n);
        return int'($signed(n.ref1)) > 0;
    endfunction

    function automatic int pick_ref(rfcs_pkg::nbr_t n, bit second);
        return second ? int'($signed(n.ref1)) : int'(n.ref0);
    endfunction

    function automatic bit nb_has(rfcs_pkg::nbr_t n, logic [1:0] frame);
        return int'(n.ref0) == int'(frame) || int'($signed(n.ref1)) == int'(frame);
    endfunction

    function automatic logic [rfcs_pkg::CTX_W-1:0] predict_context(rfcs_pkg::req_t q,
                                                                   rfcs_pkg::cfg_t c);
        rfcs_pkg::nbr_t l, a, e, s, k;
        int   lf, af, fx, v0, v1, r, vra, vrl, vrc, rfs, ctx;
        bit   li, ai, lsg, asg, var_sel, kg;
        l       = q.left;
        a       = q.above;
        li      = nb_intra(l);
        ai      = nb_intra(a);
        fx      = int'(c.fixed_ref);
        v0      = int'(c.comp_var_ref_first);
        v1      = int'(c.comp_var_ref_second);
        var_sel = !c.ref_sign_bias[c.fixed_ref];
        e       = a.valid ? a : l;
        ctx     = 0;
        case (q.command)
            rfcs_pkg::CMD_INTERP:
            begin
                lf = (l.valid && l.inter_mode) ? int'(l.filter) : int'(rfcs_pkg::NO_FILTER);
                af = (a.valid && a.inter_mode) ? int'(a.filter) : int'(rfcs_pkg::NO_FILTER);
                if (lf == af)
                    ctx = lf;
                else if (lf == int'(rfcs_pkg::NO_FILTER))
                    ctx = af;
                else if (af == int'(rfcs_pkg::NO_FILTER))
                    ctx = lf;
                else
                    ctx = int'(rfcs_pkg::NO_FILTER);
            end
            rfcs_pkg::CMD_INTRA_INTER:
            begin
                if (a.valid && l.valid)
                    ctx = (li && ai) ? 3 : int'(li || ai);
                else if (a.valid || l.valid)
                    ctx = nb_intra(e) ? 2 : 0;
                else
                    ctx = 0;
            end
            rfcs_pkg::CMD_COMP_INTER:
            begin
                if (a.valid && l.valid)
                begin
                    if (!nb_comp(a) && !nb_comp(l))
                        ctx = int'((int'(a.ref0) == fx) ^ (int'(l.ref0) == fx));
                    else if (!nb_comp(a))
                        ctx = 2 + int'(int'(a.ref0) == fx || ai);
                    else if (!nb_comp(l))
                        ctx = 2 + int'(int'(l.ref0) == fx || li);
                    else
                        ctx = 4;
                end
                else if (a.valid || l.valid)
                    ctx = nb_comp(e) ? 3 : int'(int'(e.ref0) == fx);
                else
                    ctx = 1;
            end
            rfcs_pkg::CMD_COMP_REF:
            begin
                if (a.valid && l.valid)
                begin
                    if (ai && li)
                        ctx = 2;
                    else if (ai || li)
                    begin
                        k   = ai ? l : a;
                        r   = nb_comp(k) ? pick_ref(k, var_sel) : pick_ref(k, 1'b0);
                        ctx = (r != v1) ? 3 : 1;
                    end
                    else
                    begin
                        lsg = !nb_comp(l);
                        asg = !nb_comp(a);
                        vra = asg ? pick_ref(a, 1'b0) : pick_ref(a, var_sel);
                        vrl = lsg ? pick_ref(l, 1'b0) : pick_ref(l, var_sel);
                        if (vra == vrl && v1 == vra)
                            ctx = 0;
                        else if (lsg && asg)
                        begin
                            if ((vra == fx && vrl == v0) || (vrl == fx && vra == v0))
                                ctx = 4;
                            else if (vra == vrl)
                                ctx = 3;
                            else
                                ctx = 1;
                        end
                        else if (lsg || asg)
                        begin
                            vrc = lsg ? vra : vrl;
                            rfs = asg ? vra : vrl;
                            if (vrc == v1 && rfs != v1)
                                ctx = 1;
                            else if (rfs == v1 && vrc != v1)
                                ctx = 2;
                            else
                                ctx = 4;
                        end
                        else
                            ctx = (vra == vrl) ? 4 : 2;
                    end
                end
                else if (a.valid || l.valid)
                begin
                    if (nb_intra(e))
                        ctx = 2;
                    else if (nb_comp(e))
                        ctx = (pick_ref(e, var_sel) != v1) ? 4 : 0;
                    else
                        ctx = (pick_ref(e, 1'b0) != v1) ? 3 : 0;
                end
                else
                    ctx = 2;
            end
            rfcs_pkg::CMD_SINGLE_P1:
            begin
                if (a.valid && l.valid)
                begin
                    if (ai && li)
                        ctx = 2;
                    else if (ai || li)
                    begin
                        k = ai ? l : a;
                        if (!nb_comp(k))
                            ctx = (k.ref0 == rfcs_pkg::REF_LAST) ? 4 : 0;
                        else
                            ctx = 1 + int'(nb_has(k, rfcs_pkg::REF_LAST));
                    end
                    else if (!nb_comp(a) && !nb_comp(l))
                        ctx = 2 * int'(a.ref0 == rfcs_pkg::REF_LAST)
                            + 2 * int'(l.ref0 == rfcs_pkg::REF_LAST);
                    else if (nb_comp(a) && nb_comp(l))
                        ctx = 1 + int'(nb_has(a, rfcs_pkg::REF_LAST)
                                       || nb_has(l, rfcs_pkg::REF_LAST));
                    else
                    begin
                        s = nb_comp(a) ? l : a;
                        k = nb_comp(a) ? a : l;
                        if (s.ref0 == rfcs_pkg::REF_LAST)
                            ctx = 3 + int'(nb_has(k, rfcs_pkg::REF_LAST));
                        else
                            ctx = int'(nb_has(k, rfcs_pkg::REF_LAST));
                    end
                end
                else if (a.valid || l.valid)
                begin
                    if (nb_intra(e))
                        ctx = 2;
                    else if (!nb_comp(e))
                        ctx = (e.ref0 == rfcs_pkg::REF_LAST) ? 4 : 0;
                    else
                        ctx = 1 + int'(nb_has(e, rfcs_pkg::REF_LAST));
                end
                else
                    ctx = 2;
            end
            rfcs_pkg::CMD_SINGLE_P2:
            begin
                if (a.valid && l.valid)
                begin
                    if (ai && li)
                        ctx = 2;
                    else if (ai || li)
                    begin
                        k = ai ? l : a;
                        if (!nb_comp(k))
                            ctx = (k.ref0 == rfcs_pkg::REF_LAST)
                                ? 3 : 4 * int'(k.ref0 == rfcs_pkg::REF_GOLDEN);
                        else
                            ctx = 1 + 2 * int'(nb_has(k, rfcs_pkg::REF_GOLDEN));
                    end
                    else if (!nb_comp(a) && !nb_comp(l))
                    begin
                        if (a.ref0 == rfcs_pkg::REF_LAST && l.ref0 == rfcs_pkg::REF_LAST)
                            ctx = 3;
                        else if (a.ref0 == rfcs_pkg::REF_LAST || l.ref0 == rfcs_pkg::REF_LAST)
                        begin
                            k   = (a.ref0 == rfcs_pkg::REF_LAST) ? l : a;
                            ctx = 4 * int'(k.ref0 == rfcs_pkg::REF_GOLDEN);
                        end
                        else
                            ctx = 2 * int'(a.ref0 == rfcs_pkg::REF_GOLDEN)
                                + 2 * int'(l.ref0 == rfcs_pkg::REF_GOLDEN);
                    end
                    else if (nb_comp(a) && nb_comp(l))
                    begin
                        if (a.ref0 == l.ref0 && a.ref1 == l.ref1)
                            ctx = 3 * int'(nb_has(a, rfcs_pkg::REF_GOLDEN)
                                           || nb_has(l, rfcs_pkg::REF_GOLDEN));
                        else
                            ctx = 2;
                    end
                    else
                    begin
                        s  = nb_comp(a) ? l : a;
                        k  = nb_comp(a) ? a : l;
                        kg = nb_has(k, rfcs_pkg::REF_GOLDEN);
                        if (s.ref0 == rfcs_pkg::REF_GOLDEN)
                            ctx = 3 + int'(kg);
                        else if (s.ref0 == rfcs_pkg::REF_ALT)
                            ctx = int'(kg);
                        else
                            ctx = 1 + 2 * int'(kg);
                    end
                end
                else if (a.valid || l.valid)
                begin
                    if (nb_intra(e) || (e.ref0 == rfcs_pkg::REF_LAST && !nb_comp(e)))
                        ctx = 2;
                    else if (!nb_comp(e))
                        ctx = 4 * int'(e.ref0 == rfcs_pkg::REF_GOLDEN);
                    else
                        ctx = 3 * int'(nb_has(e, rfcs_pkg::REF_GOLDEN));
                end
                else
                    ctx = 2;
            end
            default:
                ctx = 0;
        endcase
        return rfcs_pkg::CTX_W'(ctx);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rfcs_pkg::req_t seen;
        ctx_expect_t    exp_item;
        if (!rst_n)
        begin
            ctx_expect_q.delete();
            frame_cfg = '{2'd3, 2'd1, 2'd2, 4'd0};
            pending   = 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (ctx_expect_q.size() == 0)
                    report_mismatch($sformatf("unexpected result: context %0d", res.context_res));
                else
                begin
                    exp_item = ctx_expect_q.pop_front();
                    if (res.context_res !== exp_item.ctx)
                        report_mismatch($sformatf(
                            "context_res: cmd %0d left %h above %h expected %0d got %0d",
                            exp_item.rq.command, exp_item.rq.left, exp_item.rq.above,
                            exp_item.ctx, res.context_res));
                end
            end
            if (req.valid && req.ready)
            begin
                seen.command          = req.command;
                seen.left.valid       = req.left_valid;
                seen.left.inter_mode  = req.left_inter_mode;
                seen.left.filter      = req.left_filter;
                seen.left.ref0        = req.left_ref0;
                seen.left.ref1        = req.left_ref1;
                seen.above.valid      = req.above_valid;
                seen.above.inter_mode = req.above_inter_mode;
                seen.above.filter     = req.above_filter;
                seen.above.ref0       = req.above_ref0;
                seen.above.ref1       = req.above_ref1;
                exp_item.rq  = seen;
                exp_item.ctx = predict_context(seen, frame_cfg);
                ctx_expect_q.push_back(exp_item);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    rfcs_pkg::REG_FIXED_REF:
                        frame_cfg.fixed_ref = cfg_data[1:0];
                    rfcs_pkg::REG_COMP_VAR_REF_FIRST:
                        frame_cfg.comp_var_ref_first = cfg_data[1:0];
                    rfcs_pkg::REG_COMP_VAR_REF_SECOND:
                        frame_cfg.comp_var_ref_second = cfg_data[1:0];
                    rfcs_pkg::REG_REF_SIGN_BIAS:
                        frame_cfg.ref_sign_bias = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (check_end && ctx_expect_q.size() != 0)
            begin
                report_mismatch($sformatf("%0d expected results never arrived",
                                          ctx_expect_q.size()));
                ctx_expect_q.delete();
            end
            pending = ctx_expect_q.size();
        end
    end

endmodule

### verif/tb_top.sv
// top of the context selector testbench: clock, reset, stimulus and verdict
module tb_top;

    localparam int CYCLE_LIMIT = 200000;
    localparam int N_PHASES = 10;
    localparam int PHASE_ITEMS = 95;
    localparam logic signed [2:0] NO_SECOND = -3'sd1;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [rfcs_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [rfcs_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            check_end;
    int                              pending;
    int                              fail_cnt;
    int                              cycle_cnt = 0;
    int                              sent_cnt = 0;
    bit                              send_gap_on = 1'b1;
    bit                              stall_on = 1'b1;

    rfcs_req_if req_if ();
    rfcs_res_if res_if ();

    ref_frame_context_select u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_if),
        .res       (res_if)
    );

    rfcs_context_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .check_end (check_end),
        .req       (req_if),
        .res       (res_if),
        .pending   (pending),
        .fail_cnt  (fail_cnt)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
            $display("ref_frame_context_select: mismatch");
            $finish;
        end
    end

    // result side back-pressure
    initial
    begin
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_on && $urandom_range(0, 5) == 0)
            begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
            res_if.ready <= 1'b1;
        end
    end

    function automatic rfcs_pkg::nbr_t nb(bit valid, bit inter_mode, int filter, int r0,
                                          int r1);
        rfcs_pkg::nbr_t n;
        n.valid      = valid;
        n.inter_mode = inter_mode;
        n.filter     = 2'(filter);
        n.ref0       = 2'(r0);
        n.ref1       = 3'(r1);
        return n;
    endfunction

    function automatic rfcs_pkg::req_t make_req(logic [rfcs_pkg::CMD_W-1:0] cmd,
                                                rfcs_pkg::nbr_t l, rfcs_pkg::nbr_t a);
        rfcs_pkg::req_t r;
        r.command = cmd;
        r.left    = l;
        r.above   = a;
        return r;
    endfunction

    function automatic rfcs_pkg::nbr_t rand_nbr();
        rfcs_pkg::nbr_t n;
        n.valid      = ($urandom_range(0, 7) != 0);
        n.inter_mode = ($urandom_range(0, 3) != 0);
        n.filter     = 2'($urandom_range(0, 3));
        n.ref0       = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 4) == 0)
            n.ref1 = 3'($urandom_range(0, 7));
        else if (n.ref0 != rfcs_pkg::REF_INTRA && $urandom_range(0, 1) == 1)
            n.ref1 = 3'($urandom_range(1, 3));
        else
            n.ref1 = NO_SECOND;
        return n;
    endfunction

    task automatic send_req(rfcs_pkg::req_t r);
        if (send_gap_on && $urandom_range(0, 4) == 0)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        req_if.valid            <= 1'b1;
        req_if.command          <= r.command;
        req_if.left_valid       <= r.left.valid;
        req_if.left_inter_mode  <= r.left.inter_mode;
        req_if.left_filter      <= r.left.filter;
        req_if.left_ref0        <= r.left.ref0;
        req_if.left_ref1        <= r.left.ref1;
        req_if.above_valid      <= r.above.valid;
        req_if.above_inter_mode <= r.above.inter_mode;
        req_if.above_filter     <= r.above.filter;
        req_if.above_ref0       <= r.above.ref0;
        req_if.above_ref1       <= r.above.ref1;
        do
            @(posedge clk);
        while (!req_if.ready);
        sent_cnt++;
        @(negedge clk);
    endtask

    task automatic write_reg(logic [rfcs_pkg::CFG_IDX_W-1:0] idx,
                             logic [rfcs_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
    endtask

    task automatic apply_config(rfcs_pkg::cfg_t c);
        write_reg(rfcs_pkg::REG_FIXED_REF, {2'b00, c.fixed_ref});
        write_reg(rfcs_pkg::REG_COMP_VAR_REF_FIRST, {2'b00, c.comp_var_ref_first});
        write_reg(rfcs_pkg::REG_COMP_VAR_REF_SECOND, {2'b00, c.comp_var_ref_second});
        write_reg(rfcs_pkg::REG_REF_SIGN_BIAS, c.ref_sign_bias);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [1:0] rand_frame();
        return ($urandom_range(0, 9) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
    endfunction

    initial
    begin
        rfcs_pkg::cfg_t phase_cfgs [7];
        rfcs_pkg::cfg_t c;
        rfcs_pkg::req_t rq;
        phase_cfgs = '{
            '{2'd3, 2'd1, 2'd2, 4'b0000},
            '{2'd1, 2'd1, 2'd1, 4'b0000},
            '{2'd3, 2'd3, 2'd3, 4'b1111},
            '{2'd1, 2'd2, 2'd3, 4'b0101},
            '{2'd2, 2'd3, 2'd1, 4'b1010},
            '{2'd0, 2'd0, 2'd0, 4'b0001},
            '{2'd2, 2'd1, 2'd3, 4'b0100}
        };
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = '0;
        cfg_data                = '0;
        check_end               = 1'b0;
        req_if.valid            = 1'b0;
        req_if.command          = '0;
        req_if.left_valid       = 1'b0;
        req_if.left_inter_mode  = 1'b0;
        req_if.left_filter      = '0;
        req_if.left_ref0        = '0;
        req_if.left_ref1        = '0;
        req_if.above_valid      = 1'b0;
        req_if.above_inter_mode = 1'b0;
        req_if.above_filter     = '0;
        req_if.above_ref0       = '0;
        req_if.above_ref1       = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed items under the reset register values
        send_req(make_req(rfcs_pkg::CMD_INTERP, nb(1, 1, 0, 1, -1), nb(1, 1, 0, 2, -1)));
        send_req(make_req(rfcs_pkg::CMD_INTERP, nb(1, 1, 1, 1, -1), nb(1, 1, 2, 3, -1)));
        send_req(make_req(rfcs_pkg::CMD_INTERP, nb(1, 1, 3, 1, -1), nb(1, 1, 2, 3, -1)));
        send_req(make_req(rfcs_pkg::CMD_INTERP, nb(0, 1, 2, 1, -1), nb(1, 1, 1, 2, -1)));
        send_req(make_req(rfcs_pkg::CMD_INTERP, nb(1, 0, 2, 0, -1), nb(1, 1, 3, 3, 3)));
        send_req(make_req(rfcs_pkg::CMD_INTRA_INTER, nb(1, 0, 0, 0, -1), nb(1, 0, 0, 0, 0)));
        send_req(make_req(rfcs_pkg::CMD_INTRA_INTER, nb(1, 0, 0, 0, -1), nb(1, 1, 0, 2, -1)));
        send_req(make_req(rfcs_pkg::CMD_INTRA_INTER, nb(0, 1, 0, 3, -1), nb(1, 0, 0, 0, -1)));
        send_req(make_req(rfcs_pkg::CMD_INTRA_INTER, nb(1, 1, 0, 3, 2), nb(0, 0, 0, 0, -1)));
        send_req(make_req(rfcs_pkg::CMD_INTRA_INTER, nb(0, 1, 3, 3, 3), nb(0, 1, 3, 3, 3)));
        send_req(make_req(rfcs_pkg::CMD_COMP_INTER, nb(1, 1, 0, 1, -1), nb(1, 1, 0, 3, -1)));
        send_req(make_req(rfcs_pkg::CMD_COMP_INTER, nb(1, 1, 0, 3, 2), nb(1, 0, 0, 0, -1)));
        send_req(make_req(rfcs_pkg::CMD_COMP_INTER, nb(1, 1, 0, 3, 1), nb(1, 1, 0, 3, 2)));
        send_req(make_req(rfcs_pkg::CMD_COMP_INTER, nb(0, 1, 0, 3, 1), nb(0, 1, 0, 3, 2)));
        send_req(make_req(rfcs_pkg::CMD_COMP_INTER, nb(1, 1, 0, 3, 1), nb(0, 0, 0, 0, -1)));
        send_req(make_req(rfcs_pkg::CMD_COMP_REF, nb(1, 0, 0, 0, -1), nb(1, 0, 0, 0, 0)));
        send_req(make_req(rfcs_pkg::CMD_COMP_REF, nb(1, 0, 0, 0, -1), nb(1, 1, 0, 3, 2)));
        send_req(make_req(rfcs_pkg::CMD_COMP_REF, nb(1, 1, 0, 3, -1), nb(1, 1, 0, 1, -1)));
        send_req(make_req(rfcs_pkg::CMD_COMP_REF, nb(1, 1, 0, 3, 2), nb(1, 1, 0, 3, 2)));
        send_req(make_req(rfcs_pkg::CMD_COMP_REF, nb(0, 1, 0, 3, 1), nb(1, 1, 0, 2, -1)));
        send_req(make_req(rfcs_pkg::CMD_SINGLE_P1, nb(1, 1, 0, 1, -1), nb(1, 1, 0, 1, -2)));
        send_req(make_req(rfcs_pkg::CMD_SINGLE_P1, nb(1, 1, 0, 1, -4), nb(1, 1, 0, 3, 1)));
        send_req(make_req(rfcs_pkg::CMD_SINGLE_P2, nb(1, 1, 0, 3, 2), nb(1, 1, 0, 3, 2)));
        send_req(make_req(rfcs_pkg::CMD_SINGLE_P2, nb(1, 1, 0, 3, -1), nb(1, 1, 0, 1, 2)));
        send_req(make_req(3'd6, nb(1, 1, 3, 3, 3), nb(1, 1, 3, 3, 3)));
        send_req(make_req(3'd7, nb(1, 1, 1, 2, -4), nb(0, 0, 2, 1, 1)));

        for (int p = 0; p < N_PHASES; p++)
        begin
            wait_drained();
            if (p < 7)
                c = phase_cfgs[p];
            else
            begin
                c.fixed_ref           = rand_frame();
                c.comp_var_ref_first  = rand_frame();
                c.comp_var_ref_second = rand_frame();
                c.ref_sign_bias       = 4'($urandom_range(0, 15));
            end
            apply_config(c);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 32 == 0)
                begin
                    send_gap_on = (p != N_PHASES - 1) && ($urandom_range(0, 2) != 0);
                    stall_on    = (p != N_PHASES - 1) && ($urandom_range(0, 2) != 0);
                end
                rq.command = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                          : 3'($urandom_range(0, 5));
                rq.left    = rand_nbr();
                rq.above   = rand_nbr();
                send_req(rq);
            end
        end

        wait_drained();
        check_end <= 1'b1;
        @(negedge clk);
        check_end <= 1'b0;
        @(negedge clk);
        $display("run covered %0d context requests over %0d register settings,", sent_cnt,
                 N_PHASES + 1);
        $display("all commands including unused codes, with and without idling on both sides");
        if (fail_cnt == 0)
            $display("ref_frame_context_select: match");
        else
            $display("ref_frame_context_select: mismatch");
        $finish;
    end

endmodule

### ref_frame_context_select.f
src/rfcs_pkg.sv
src/rfcs_if.sv
src/rfcs_cfg.sv
src/rfcs_ctx.sv
src/ref_frame_context_select.sv
src/rfcs_checker.sv
verif/rfcs_checker.sv
verif/tb_top.sv
